/* rtl/window_median_filter_unit_defines.svh */
// Assertion macros used by the port checker file of the window median filter.
`ifndef WINDOW_MEDIAN_FILTER_UNIT_DEFINES_SVH
`define WINDOW_MEDIAN_FILTER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WMF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WMF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/wmf_pkg.sv */
// Shared types and constants of the window median filter.
package wmf_pkg;

  localparam int PIX_W        = 8;
  localparam int WIDTH_CFG_W  = 11;
  localparam int HEIGHT_CFG_W = 12;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_IDX_W    = 1;
  localparam int IN_ROW_W     = 13;
  localparam int OUT_ROW_W    = 12;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = 2;
  localparam int FIFO_CNT_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } wmf_reg_e;

endpackage

/* rtl/wmf_line_ram.sv */
// One row of the line store: single write port, single registered read port.
module wmf_line_ram #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(DEPTH)-1:0]      waddr_i,
  input  logic [wmf_pkg::PIX_W-1:0]     wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(DEPTH)-1:0]      raddr_i,
  output logic [wmf_pkg::PIX_W-1:0]     rdata_o
);

  logic [wmf_pkg::PIX_W-1:0] mem [DEPTH];
  logic [wmf_pkg::PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/wmf_median.sv */
// Rank-based median select over one full window of pixels.
module wmf_median #(
  parameter int TAPS = 9
) (
  input  logic [wmf_pkg::PIX_W-1:0] taps_i [TAPS],
  output logic [wmf_pkg::PIX_W-1:0] median_o
);

  localparam int CNT_W = $clog2(TAPS + 1);
  localparam logic [CNT_W-1:0] Mid = CNT_W'(TAPS / 2);

  // Each tap counts how many taps sort ahead of it; ties are broken by position,
  // so exactly one tap carries the middle rank.
  always_comb begin
    logic [TAPS-1:0] ahead;
    median_o = '0;
    for (int i = 0; i < TAPS; i++) begin
      for (int j = 0; j < TAPS; j++) begin
        ahead[j] = (taps_i[j] < taps_i[i]) || ((taps_i[j] == taps_i[i]) && (j < i));
      end
      if (CNT_W'($countones(ahead)) == Mid) begin
        median_o = median_o | taps_i[i];
      end
    end
  end

endmodule

/* rtl/window_median_filter_unit.sv */
// A result passes through the s1 and s2 registers and the output queue after the item that completes its window.
// Results trail the pixel stream by HALF*W + HALF items; drain items flush the tail.
// Throughput: one pixel per cycle while in_stall_o is low, set by one line-store read per row bank per cycle.
// A four-entry output queue lets input continue while results wait downstream.
// Reset clears counters and queue and loads 640 x 480; the line store is not cleared.
module window_median_filter_unit #(
  parameter int WINDOW_SIZE = 3,
  parameter int MAX_WIDTH   = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wmf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wmf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [wmf_pkg::PIX_W-1:0]          pixel_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [wmf_pkg::PIX_W-1:0]          pixel_out_o,
  output logic                               frame_last_o
);

  localparam int HALF   = WINDOW_SIZE / 2;
  localparam int SPAN   = 2 * HALF + 1;
  localparam int TAPS   = SPAN * SPAN;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int BANK_W = $clog2(SPAN);
  localparam int PIX_W  = wmf_pkg::PIX_W;
  localparam int IROW_W = wmf_pkg::IN_ROW_W;
  localparam int OROW_W = wmf_pkg::OUT_ROW_W;
  localparam int WidthResetEff =
    (wmf_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : wmf_pkg::WIDTH_RESET;

  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } ctrl_t;

  // Frame geometry, kept as effective size minus one.
  logic [COL_W-1:0]  w_m1_q, w_m1_d;
  logic [OROW_W-1:0] h_m1_q, h_m1_d;
  logic              cfg_restart;
  logic [wmf_pkg::WIDTH_CFG_W+1:0] cfg_w_ext;
  logic [wmf_pkg::HEIGHT_CFG_W-1:0] cfg_h;

  logic [COL_W-1:0]  in_col_q, in_col_d;
  logic [IROW_W-1:0] in_row_q, in_row_d;
  logic [BANK_W-1:0] in_bank_q, in_bank_d;
  logic [COL_W-1:0]  out_col_q, out_col_d;
  logic [OROW_W-1:0] out_row_q, out_row_d;

  logic  accept;
  logic  at_row_end;
  logic  row_in_frame;
  ctrl_t cur_ctrl;

  logic             s1_valid_q;
  ctrl_t            s1_ctrl_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [BANK_W-1:0] s1_bank_q;

  logic [PIX_W-1:0] bank_rdata [SPAN];
  logic [PIX_W-1:0] column [SPAN];
  logic [PIX_W-1:0] win_q [SPAN][SPAN];
  logic [PIX_W-1:0] taps [TAPS];
  logic [PIX_W-1:0] median;

  logic             s2_valid_q;
  logic             s2_interior_q;
  logic             s2_last_q;
  logic [PIX_W-1:0] result;

  logic [PIX_W-1:0]                 fifo_pix_q  [wmf_pkg::FIFO_DEPTH];
  logic                             fifo_last_q [wmf_pkg::FIFO_DEPTH];
  logic [wmf_pkg::FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [wmf_pkg::FIFO_CNT_W-1:0]   count_q, count_d;
  logic [wmf_pkg::FIFO_CNT_W:0]     committed;
  logic                             fifo_wr, fifo_rd;

  // Configuration decode and size clamping.
  always_comb begin
    cfg_w_ext   = (wmf_pkg::WIDTH_CFG_W + 2)'(cfg_data_i[wmf_pkg::WIDTH_CFG_W-1:0]);
    cfg_h       = cfg_data_i[wmf_pkg::HEIGHT_CFG_W-1:0];
    w_m1_d      = w_m1_q;
    h_m1_d      = h_m1_q;
    cfg_restart = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        wmf_pkg::REG_IMAGE_WIDTH: begin
          cfg_restart = 1'b1;
          if (cfg_w_ext == '0) begin
            w_m1_d = '0;
          end else if (cfg_w_ext > (wmf_pkg::WIDTH_CFG_W + 2)'(MAX_WIDTH)) begin
            w_m1_d = COL_W'(MAX_WIDTH - 1);
          end else begin
            w_m1_d = COL_W'(cfg_w_ext - 1'b1);
          end
        end
        wmf_pkg::REG_IMAGE_HEIGHT: begin
          cfg_restart = 1'b1;
          h_m1_d = (cfg_h == '0) ? '0 : cfg_h - 1'b1;
        end
        default: begin
          cfg_restart = 1'b0;
        end
      endcase
    end
  end

  assign accept       = in_valid_i && !in_stall_o;
  assign at_row_end   = (in_col_q == w_m1_q);
  assign row_in_frame = (in_row_q <= IROW_W'(h_m1_q));

  // The output side starts once the first window corner has arrived.
  always_comb begin
    cur_ctrl.emit = (in_row_q > IROW_W'(HALF)) ||
                    ((in_row_q == IROW_W'(HALF)) && (in_col_q >= COL_W'(HALF)));
    cur_ctrl.interior =
      (out_row_q >= OROW_W'(HALF)) &&
      (({1'b0, out_row_q} + (OROW_W + 1)'(HALF)) <= {1'b0, h_m1_q}) &&
      (out_col_q >= COL_W'(HALF)) &&
      (({1'b0, out_col_q} + (COL_W + 1)'(HALF)) <= {1'b0, w_m1_q});
    cur_ctrl.last = (out_row_q >= h_m1_q) && (out_col_q >= w_m1_q);
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    in_bank_d = in_bank_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      in_bank_d = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (accept) begin
      if (at_row_end) begin
        in_col_d  = '0;
        if (in_row_q != '1) begin
          in_row_d = in_row_q + 1'b1;
        end
        in_bank_d = (in_bank_q == BANK_W'(SPAN - 1)) ? '0 : in_bank_q + 1'b1;
      end else begin
        in_col_d = in_col_q + 1'b1;
      end
      if (cur_ctrl.emit) begin
        if (cur_ctrl.last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          in_bank_d = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (out_col_q == w_m1_q) begin
          out_col_d = '0;
          out_row_d = out_row_q + 1'b1;
        end else begin
          out_col_d = out_col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_m1_q    <= COL_W'(WidthResetEff - 1);
      h_m1_q    <= OROW_W'(wmf_pkg::HEIGHT_RESET - 1);
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_bank_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      w_m1_q    <= w_m1_d;
      h_m1_q    <= h_m1_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      in_bank_q <= in_bank_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // One RAM per ring row; the bank of the current row takes the write.
  for (genvar b = 0; b < SPAN; b++) begin : g_bank
    wmf_line_ram #(
      .DEPTH(MAX_WIDTH)
    ) u_line_ram (
      .clk_i  (clk_i),
      .we_i   (accept && row_in_frame && (in_bank_q == BANK_W'(b))),
      .waddr_i(in_col_q),
      .wdata_i(pixel_in_i),
      .re_i   (accept),
      .raddr_i(in_col_q),
      .rdata_o(bank_rdata[b])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_ctrl_q  <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s1_ctrl_q  <= cur_ctrl;
      s2_valid_q <= s1_valid_q && s1_ctrl_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pix_q      <= pixel_in_i;
    s1_bank_q     <= in_bank_q;
    s2_interior_q <= s1_ctrl_q.interior;
    s2_last_q     <= s1_ctrl_q.last;
  end

  // Column of the newest input: the oldest ring row sits one bank past the current one.
  always_comb begin
    logic [BANK_W:0] sel;
    for (int k = 0; k < SPAN - 1; k++) begin
      sel = {1'b0, s1_bank_q} + (BANK_W + 1)'(k + 1);
      if (sel >= (BANK_W + 1)'(SPAN)) begin
        sel = sel - (BANK_W + 1)'(SPAN);
      end
      column[k] = bank_rdata[sel[BANK_W-1:0]];
    end
    column[SPAN-1] = s1_pix_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      for (int c = 0; c < SPAN - 1; c++) begin
        for (int r = 0; r < SPAN; r++) begin
          win_q[c][r] <= win_q[c+1][r];
        end
      end
      for (int r = 0; r < SPAN; r++) begin
        win_q[SPAN-1][r] <= column[r];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < SPAN; c++) begin
      for (int r = 0; r < SPAN; r++) begin
        taps[c * SPAN + r] = win_q[c][r];
      end
    end
  end

  wmf_median #(
    .TAPS(TAPS)
  ) u_median (
    .taps_i  (taps),
    .median_o(median)
  );

  // The window center is the pixel HALF rows and HALF columns behind the input.
  assign result = s2_interior_q ? median : win_q[HALF][HALF];

  // Output queue; input stalls once queued plus in-flight results could overflow it.
  assign fifo_wr   = s2_valid_q;
  assign fifo_rd   = out_valid_o && !out_stall_i;
  assign committed = (wmf_pkg::FIFO_CNT_W + 1)'(count_q) +
                     (wmf_pkg::FIFO_CNT_W + 1)'(s1_valid_q && s1_ctrl_q.emit) +
                     (wmf_pkg::FIFO_CNT_W + 1)'(s2_valid_q);
  assign in_stall_o = (committed >= (wmf_pkg::FIFO_CNT_W + 1)'(wmf_pkg::FIFO_DEPTH));

  always_comb begin
    count_d = count_q;
    if (fifo_wr && !fifo_rd) begin
      count_d = count_q + 1'b1;
    end else if (!fifo_wr && fifo_rd) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (fifo_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (fifo_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_wr) begin
      fifo_pix_q[wr_ptr_q]  <= result;
      fifo_last_q[wr_ptr_q] <= s2_last_q;
    end
  end

  assign out_valid_o  = (count_q != '0);
  assign pixel_out_o  = fifo_pix_q[rd_ptr_q];
  assign frame_last_o = fifo_last_q[rd_ptr_q];

endmodule

/* rtl/wmf_port_checker.sv */
// Port-level checks of the window median filter and their binding to the top level.
`include "window_median_filter_unit_defines.svh"

module wmf_port_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_i,
  input logic                      out_valid_i,
  input logic                      out_stall_i,
  input logic [wmf_pkg::PIX_W-1:0] pixel_out_i,
  input logic                      frame_last_i
);

  // A stalled result transaction keeps its payload.
  `WMF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(pixel_out_i) && $stable(frame_last_i), "stalled result changed")

  // A result only appears after an input transaction has passed through stages s1, s2 and the output queue.
  `WMF_ASSERT_NOW(a_out_from_input, clk_i, rst_ni, $rose(out_valid_i), $past(in_valid_i && !in_stall_i, 3), "result without matching input")

  // With the output queue empty there is always room for another input.
  `WMF_ASSERT_NOW(a_no_stall_when_empty, clk_i, rst_ni, !out_valid_i, !in_stall_i, "input stalled while output queue empty")

endmodule

bind window_median_filter_unit wmf_port_checker u_wmf_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .pixel_out_i (pixel_out_o),
  .frame_last_i(frame_last_o)
);

/* dv/window_median_filter_unit_test.sv */
// Self-checking testbench of the 3x3 window median filter: stream driver, predictor and scoreboard.
`timescale 1ns / 100ps

class median_scoreboard;
  localparam int HALF        = 1;
  localparam int SPAN        = 2 * HALF + 1;
  localparam int MAX_W       = 1024;
  localparam int IN_ROW_CEIL = 'h1FFF;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_last;
  } median_result_t;

  bit [7:0]                          rows [SPAN][MAX_W];
  logic [wmf_pkg::WIDTH_CFG_W-1:0]   width_reg;
  logic [wmf_pkg::HEIGHT_CFG_W-1:0]  height_reg;
  int unsigned                       in_col, in_row, out_col, out_row;
  median_result_t                    expected_pixels[$];
  int unsigned                       errors;

  function new();
    width_reg  = wmf_pkg::WIDTH_CFG_W'(wmf_pkg::WIDTH_RESET);
    height_reg = wmf_pkg::HEIGHT_CFG_W'(wmf_pkg::HEIGHT_RESET);
    errors     = 0;
    restart();
  endfunction

  function void restart();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function int unsigned frame_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function int unsigned frame_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  // Items that follow a frame to flush its last results.
  function int unsigned drain_items();
    return frame_width() * HALF + HALF;
  endfunction

  function int unsigned pending();
    return expected_pixels.size();
  endfunction

  function void log_failure(string msg);
    errors++;
    $error("%s", msg);
  endfunction

  // Either size register restarts the frame; the line store keeps its contents.
  function void write_reg(wmf_pkg::wmf_reg_e index, logic [wmf_pkg::CFG_DATA_W-1:0] data);
    case (index)
      wmf_pkg::REG_IMAGE_WIDTH:  width_reg = data[wmf_pkg::WIDTH_CFG_W-1:0];
      wmf_pkg::REG_IMAGE_HEIGHT: height_reg = data[wmf_pkg::HEIGHT_CFG_W-1:0];
      default: return;
    endcase
    restart();
  endfunction

  // Stores one accepted pixel and predicts the output pixel it releases, if any.
  function void note_pixel(logic [7:0] pixel);
    int unsigned    w, h, r, c;
    bit             emit;
    logic [7:0]     taps[$];
    median_result_t want;

    w = frame_width();
    h = frame_height();
    emit = (in_row > HALF) || (in_row == HALF && in_col >= HALF);
    if (in_row < h) rows[in_row % SPAN][in_col] = pixel;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      if (in_row < IN_ROW_CEIL) in_row++;
    end
    if (!emit) return;

    r = out_row;
    c = out_col;
    if (r >= HALF && r + HALF < h && c >= HALF && c + HALF < w) begin
      for (int dr = 0; dr < SPAN; dr++) begin
        for (int dc = 0; dc < SPAN; dc++) begin
          taps = {taps, rows[(r - HALF + dr) % SPAN][c - HALF + dc]};
        end
      end
      taps.sort();
      want.pixel = taps[taps.size() / 2];
    end else begin
      want.pixel = rows[r % SPAN][c];
    end
    want.frame_last = (r + 1 >= h) && (c + 1 >= w);
    expected_pixels = {expected_pixels, want};

    if (want.frame_last) begin
      restart();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  function void check_pixel(logic [7:0] pixel, logic last);
    median_result_t want;
    if (expected_pixels.size() == 0) begin
      log_failure($sformatf("unexpected result: pixel_out %0d, frame_last %0d", pixel, last));
      return;
    end
    want = expected_pixels.pop_front();
    if (pixel !== want.pixel)
      log_failure($sformatf("pixel_out: expected %0d, actual %0d", want.pixel, pixel));
    if (last !== want.frame_last)
      log_failure($sformatf("frame_last: expected %0d, actual %0d", want.frame_last, last));
  endfunction

  function void report_missing();
    if (expected_pixels.size() != 0)
      log_failure($sformatf("%0d expected results never arrived", expected_pixels.size()));
  endfunction
endclass

module window_median_filter_unit_test;

  localparam int CLK_PERIOD     = 10;
  localparam int SETTLE_CYCLES  = 16;
  localparam int RX_HOLD_CYCLES = 150;
  localparam int RANDOM_ITEMS   = 450;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int TIMEOUT_NS     = 5_000_000;

  localparam logic [7:0] DIRECTED_PIXELS [13] = '{
    8'd0, 8'd255, 8'd7, 8'd200, 8'd128, 8'd1, 8'd255, 8'd0, 8'd64,
    8'd255, 8'd0, 8'd255, 8'd0
  };

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic [wmf_pkg::PIX_W-1:0]      pixel_in_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic [wmf_pkg::PIX_W-1:0]      pixel_out_o;
  logic                           frame_last_o;

  median_scoreboard median_sb;
  bit               gaps_on;
  bit               stalls_on;
  bit               rx_hold_request;
  int unsigned      items_sent;

  window_median_filter_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_in_i   (pixel_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_out_o  (pixel_out_o),
    .frame_last_o (frame_last_o)
  );

  always begin
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // Register writes, accepted pixels and accepted results, all seen at the same edge as the DUT.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (cfg_we_i) median_sb.write_reg(wmf_pkg::wmf_reg_e'(cfg_index_i), cfg_data_i);
      if (in_valid_i && !in_stall_o) median_sb.note_pixel(pixel_in_i);
      if (out_valid_o && !out_stall_i) median_sb.check_pixel(pixel_out_o, frame_last_o);
    end
  end

  // Downstream side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rx_hold_request) begin
        out_stall_i <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold_request = 1'b0;
        out_stall_i <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  task automatic send_pixel(input logic [7:0] value);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (median_sb.pending() != 0);
  endtask

  // Pixels that release no result may still be in flight once the last result is out.
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input bit set_w, input logic [wmf_pkg::CFG_DATA_W-1:0] w_cfg,
                           input bit set_h, input logic [wmf_pkg::CFG_DATA_W-1:0] h_cfg);
    if (set_w) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= wmf_pkg::REG_IMAGE_WIDTH;
      cfg_data_i  <= w_cfg;
      @(posedge clk_i);
    end
    if (set_h) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= wmf_pkg::REG_IMAGE_HEIGHT;
      cfg_data_i  <= h_cfg;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sends whole frames with their drain items; the last one may be cut short.
  task automatic run_frames(input int unsigned frames, input bit cut_last,
                            input bit narrow, input bit with_pause);
    int unsigned per_frame, stop_at, pause_at;
    logic [7:0]  value;
    per_frame = median_sb.frame_width() * median_sb.frame_height() + median_sb.drain_items();
    stop_at   = frames * per_frame;
    if (cut_last) stop_at -= $urandom_range(1, per_frame - 1);
    pause_at  = with_pause ? $urandom_range(1, stop_at - 1) : stop_at;
    for (int unsigned i = 0; i < stop_at; i++) begin
      if (i == pause_at) wait_drained();
      // Narrow frames use only 0, 1, 254 and 255 so that windows are full of ties.
      if (narrow) value = 8'($urandom_range(0, 1)) * 8'd254 + 8'($urandom_range(0, 1));
      else value = 8'($urandom_range(0, 255));
      send_pixel(value);
    end
  endtask

  initial begin
    int unsigned                    goal, pick, waited;
    logic [wmf_pkg::CFG_DATA_W-1:0] w_cfg, h_cfg;

    median_sb   = new();
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= wmf_pkg::REG_IMAGE_WIDTH;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    pixel_in_i  <= '0;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One interior window of extreme values, then frames made only of border pixels.
    configure(1'b1, 12'd3, 1'b1, 12'd3);
    foreach (DIRECTED_PIXELS[k]) send_pixel(DIRECTED_PIXELS[k]);
    settle();
    configure(1'b1, 12'h803, 1'b1, 12'd0);
    run_frames(1, 1'b0, 1'b0, 1'b0);
    settle();
    configure(1'b1, 12'd0, 1'b1, 12'd2);
    run_frames(1, 1'b0, 1'b1, 1'b0);

    // Downstream holds off while the source keeps offering, so the input must back up.
    settle();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    configure(1'b1, 12'd8, 1'b1, 12'd8);
    rx_hold_request = 1'b1;
    run_frames(1, 1'b0, 1'b0, 1'b0);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    run_frames(1, 1'b0, 1'b0, 1'b1);

    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      settle();
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: w_cfg = 12'd0;
        1: w_cfg = 12'd1;
        2: w_cfg = 12'd2;
        3: w_cfg = {1'b1, 11'($urandom_range(3, 9))};  // top bit lies outside the width field
        4: w_cfg = 12'($urandom_range(11, 24));
        default: w_cfg = 12'($urandom_range(3, 10));
      endcase
      case ($urandom_range(0, 9))
        0: h_cfg = 12'd0;
        1: h_cfg = 12'd1;
        2: h_cfg = 12'd2;
        3: h_cfg = 12'($urandom_range(11, 16));
        default: h_cfg = 12'($urandom_range(3, 10));
      endcase
      pick = $urandom_range(0, 3);
      configure(pick != 1, w_cfg, pick != 0, h_cfg);
      run_frames($urandom_range(1, 2), $urandom_range(0, 4) == 0,
                 $urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0);
    end

    settle();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    configure(1'b1, 12'd6, 1'b1, 12'd5);
    run_frames(2, 1'b0, 1'b0, 1'b0);

    in_valid_i <= 1'b0;
    for (waited = 0; waited < DRAIN_LIMIT && median_sb.pending() != 0; waited++)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    median_sb.report_missing();
    if (median_sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
